// File: rtl/core/mkte_pkg.sv
// Shared types, constants and letter tables of the multi-tap keypad text entry block.
`default_nettype none

package mkte_pkg;

    localparam int BUNDLE_SLOTS        = 8;
    localparam int IDX_W               = $clog2(BUNDLE_SLOTS);
    localparam int COUNT_W             = $clog2(BUNDLE_SLOTS + 1);
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam int CFG_DATA_W = 5;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    localparam logic [4:0] TIMEOUT_RESET = 5'd20;
    localparam logic [1:0] RELEASE_RESET = 2'd2;
    localparam logic [4:0] TICK_MAX      = 5'd31;

    localparam logic [7:0] KEY_NONE  = 8'd0;
    localparam logic [7:0] KEY_ONE   = 8'd1;
    localparam logic [7:0] KEY_LEFT  = 8'd10;
    localparam logic [7:0] KEY_SPACE = 8'd11;
    localparam logic [7:0] KEY_RIGHT = 8'd12;

    localparam logic [7:0] CHAR_NONE   = 8'd0;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;
    localparam logic [7:0] CHAR_ZERO   = 8'd48;
    localparam logic [7:0] CHAR_ONE    = 8'd49;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [6:0] ROW0_END   = 7'h0F;
    localparam logic [6:0] ROW1_START = 7'h40;
    localparam logic [6:0] ROW1_END   = 7'h4F;

    typedef enum logic [1:0] {
        CMD_ADDR  = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;
    } cmd_t;

    typedef struct packed {
        cmd_t [BUNDLE_SLOTS-1:0] cmds;
        logic [COUNT_W-1:0]      count;
    } bundle_t;

    function automatic logic [7:0] first_letter(input logic [3:0] key);
        logic [7:0] letter;
        case (key)
            4'd2:    letter = 8'd97;
            4'd3:    letter = 8'd100;
            4'd4:    letter = 8'd103;
            4'd5:    letter = 8'd106;
            4'd6:    letter = 8'd109;
            4'd7:    letter = 8'd112;
            4'd8:    letter = 8'd116;
            4'd9:    letter = 8'd119;
            default: letter = 8'd0;
        endcase
        return letter;
    endfunction

    function automatic logic [7:0] last_letter(input logic [3:0] key);
        logic [7:0] letter;
        case (key)
            4'd2:    letter = 8'd99;
            4'd3:    letter = 8'd102;
            4'd4:    letter = 8'd105;
            4'd5:    letter = 8'd108;
            4'd6:    letter = 8'd111;
            4'd7:    letter = 8'd115;
            4'd8:    letter = 8'd118;
            4'd9:    letter = 8'd122;
            default: letter = 8'd0;
        endcase
        return letter;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mkte_front.sv
// Front end: takes poll ticks, updates the entry state and builds each tick's command bundle.
`default_nettype none

module mkte_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          key_code,
    input  wire logic                                key_received,
    input  wire logic                                clear_button,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [mkte_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                queue_full,
    output logic                                     push,
    output mkte_pkg::bundle_t                        push_data
);

    typedef struct packed {
        logic [6:0]        cur;
        mkte_pkg::bundle_t b;
    } work_t;

    logic [4:0] timeout_reg;
    logic [1:0] release_reg;
    logic [6:0] cursor_reg;
    logic [7:0] char_reg,  char_next;
    logic [7:0] prev_reg,  prev_next;
    logic [7:0] held_reg,  held_next;
    logic [1:0] zero_reg,  zero_next;
    logic       armed_reg, armed_next;
    logic [4:0] ticks_reg, ticks_next;
    logic       pend_reg,  pend_next;
    logic [7:0] shown;
    logic       accept;
    work_t      w;

    function automatic work_t add_cmd(input work_t wi, input mkte_pkg::cmd_kind_t kind,
                                      input logic [7:0] value);
        work_t wo;
        wo = wi;
        wo.b.cmds[wi.b.count[mkte_pkg::IDX_W-1:0]].kind  = kind;
        wo.b.cmds[wi.b.count[mkte_pkg::IDX_W-1:0]].value = value;
        wo.b.count = wi.b.count + mkte_pkg::COUNT_W'(1);
        return wo;
    endfunction

    function automatic work_t step_right(input work_t wi);
        work_t wo;
        wo = wi;
        wo.cur = wi.cur + 7'd1;
        wo = add_cmd(wo, mkte_pkg::CMD_ADDR, {1'b0, wo.cur});
        return wo;
    endfunction

    function automatic work_t correct(input work_t wi);
        work_t wo;
        wo = wi;
        if (wi.cur > mkte_pkg::ROW0_END && wi.cur < mkte_pkg::ROW1_START)
        begin
            wo.cur = mkte_pkg::ROW1_START;
            wo = add_cmd(wo, mkte_pkg::CMD_ADDR, {1'b0, wo.cur});
        end
        else if (wi.cur > mkte_pkg::ROW1_END)
        begin
            wo.cur = '0;
            wo = add_cmd(wo, mkte_pkg::CMD_ADDR, {1'b0, wo.cur});
        end
        return wo;
    endfunction

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign push      = accept && (w.b.count != '0);
    assign push_data = w.b;

    always_comb
    begin
        w.cur      = cursor_reg;
        w.b        = '0;
        held_next  = key_received ? key_code : held_reg;
        zero_next  = zero_reg;
        armed_next = armed_reg;
        char_next  = char_reg;
        prev_next  = prev_reg;
        pend_next  = pend_reg;
        ticks_next = ticks_reg;
        shown      = char_reg;

        if (held_next == mkte_pkg::KEY_NONE)
        begin
            if (zero_reg >= release_reg)
            begin
                zero_next  = '0;
                armed_next = 1'b1;
            end
            else
            begin
                zero_next = zero_reg + 2'd1;
            end
        end
        else
        begin
            zero_next = '0;
        end

        if (ticks_reg >= timeout_reg && pend_reg)
        begin
            w         = step_right(w);
            w         = correct(w);
            prev_next = mkte_pkg::KEY_NONE;
            char_next = mkte_pkg::CHAR_NONE;
            pend_next = 1'b0;
        end

        if (held_next != mkte_pkg::KEY_NONE && armed_next)
        begin
            if (held_next != mkte_pkg::KEY_LEFT && held_next != mkte_pkg::KEY_RIGHT &&
                held_next != prev_next && prev_next != mkte_pkg::KEY_NONE &&
                prev_next != mkte_pkg::KEY_LEFT && prev_next != mkte_pkg::KEY_RIGHT)
            begin
                w = step_right(w);
                w = correct(w);
            end
            prev_next = held_next;
            pend_next = 1'b1;

            if (held_next == mkte_pkg::KEY_ONE)
            begin
                char_next = mkte_pkg::CHAR_ONE;
            end
            else if (held_next inside {[8'd2:8'd9]})
            begin
                if (char_next >= mkte_pkg::first_letter(held_next[3:0]) &&
                    char_next < mkte_pkg::last_letter(held_next[3:0]))
                begin
                    char_next = char_next + 8'd1;
                end
                else if (char_next == mkte_pkg::last_letter(held_next[3:0]))
                begin
                    char_next = held_next + mkte_pkg::CHAR_ZERO;
                end
                else
                begin
                    char_next = mkte_pkg::first_letter(held_next[3:0]);
                end
            end
            else if (held_next == mkte_pkg::KEY_LEFT)
            begin
                if (w.cur == '0)
                begin
                    w.cur = mkte_pkg::ROW1_END;
                end
                else if (w.cur == mkte_pkg::ROW1_START)
                begin
                    w.cur = mkte_pkg::ROW0_END;
                end
                else
                begin
                    w.cur = w.cur - 7'd1;
                end
                pend_next = 1'b0;
                char_next = mkte_pkg::CHAR_NONE;
                w = add_cmd(w, mkte_pkg::CMD_ADDR, {1'b0, w.cur});
            end
            else if (held_next == mkte_pkg::KEY_SPACE)
            begin
                char_next = (char_next == mkte_pkg::CHAR_SPACE) ? mkte_pkg::CHAR_ZERO
                                                                : mkte_pkg::CHAR_SPACE;
            end
            else if (held_next == mkte_pkg::KEY_RIGHT)
            begin
                pend_next = 1'b0;
                char_next = mkte_pkg::CHAR_NONE;
                w = step_right(w);
            end

            if (held_next inside {[8'd1:8'd9]} || held_next == mkte_pkg::KEY_SPACE)
            begin
                shown = char_next;
                if (shown inside {[mkte_pkg::LOWER_A:mkte_pkg::LOWER_Z]})
                begin
                    shown = shown - mkte_pkg::CASE_OFFSET;
                end
                w = add_cmd(w, mkte_pkg::CMD_CHAR, shown);
                w = add_cmd(w, mkte_pkg::CMD_ADDR, {1'b0, w.cur});
            end
            w = correct(w);

            ticks_next = '0;
            armed_next = 1'b0;
        end

        if (clear_button)
        begin
            w         = add_cmd(w, mkte_pkg::CMD_CLEAR, 8'd0);
            w.cur     = '0;
            prev_next = mkte_pkg::KEY_NONE;
            char_next = mkte_pkg::CHAR_NONE;
            pend_next = 1'b0;
        end

        if (ticks_next != mkte_pkg::TICK_MAX)
        begin
            ticks_next = ticks_next + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= mkte_pkg::TIMEOUT_RESET;
            release_reg <= mkte_pkg::RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mkte_pkg::CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data[4:0];
            end
            else
            begin
                release_reg <= cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            char_reg   <= '0;
            prev_reg   <= '0;
            held_reg   <= '0;
            zero_reg   <= '0;
            armed_reg  <= 1'b1;
            ticks_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else if (accept)
        begin
            cursor_reg <= w.cur;
            char_reg   <= char_next;
            prev_reg   <= prev_next;
            held_reg   <= held_next;
            zero_reg   <= zero_next;
            armed_reg  <= armed_next;
            ticks_reg  <= ticks_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mkte_queue.sv
// Short queue of command bundles between the front end and the command serializer.
`default_nettype none

module mkte_queue
#(
    parameter int DEPTH = mkte_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire mkte_pkg::bundle_t  push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output mkte_pkg::bundle_t       head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mkte_pkg::bundle_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/mkte_back.sv
// Back end: walks the head bundle one command per cycle into the output register while out_ready is high.
`default_nettype none

module mkte_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire mkte_pkg::bundle_t  head_data,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              command_kind,
    output logic [7:0]              command_value,
    output logic                    last_command
);

    logic [mkte_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    mkte_pkg::cmd_t             cmd_reg;
    logic                       last_reg;
    mkte_pkg::cmd_t             cmd;
    logic                       is_last;
    logic                       load;

    assign load    = head_valid && (!valid_reg || out_ready);
    assign cmd     = head_data.cmds[idx_reg];
    assign is_last = (mkte_pkg::COUNT_W'(idx_reg) + mkte_pkg::COUNT_W'(1)) == head_data.count;
    assign pop     = load && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + mkte_pkg::IDX_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= cmd;
            last_reg <= is_last;
        end
    end

    assign out_valid     = valid_reg;
    assign command_kind  = cmd_reg.kind;
    assign command_value = cmd_reg.value;
    assign last_command  = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/multitap_keypad_text_entry.sv
// Top level of the multi-tap keypad text entry block: front end, bundle queue and serializer.
// A tick is accepted while in_ready is high; its commands pass the queue, then the output
// register, and leave one per cycle while out_ready is high. A tick holds up to 5 commands;
// the queue lets further ticks enter meanwhile, and ticks without commands push no bundle.
// Reset clears the entry state, empties the queue and loads timeout 20 and release 2.
`default_nettype none

module multitap_keypad_text_entry
#(
    parameter int QUEUE_DEPTH = mkte_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      key_code,
    input  wire logic                            key_received,
    input  wire logic                            clear_button,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           command_kind,
    output logic [7:0]                           command_value,
    output logic                                 last_command,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [mkte_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic              queue_full;
    logic              push;
    mkte_pkg::bundle_t push_data;
    logic              pop;
    logic              head_valid;
    mkte_pkg::bundle_t head_data;

    mkte_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .key_code     (key_code),
        .key_received (key_received),
        .clear_button (clear_button),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (queue_full),
        .push         (push),
        .push_data    (push_data)
    );

    mkte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    mkte_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command_kind  (command_kind),
        .command_value (command_value),
        .last_command  (last_command)
    );

endmodule

`default_nettype wire
